FILE: design/nbtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbtm_pkg
// Shared types and constants for the neighbor table with running peak RSSI.
// ----------------------------------------------------------------------------
package nbtm_pkg;

    // Default number of table slots
    localparam int unsigned DEF_TABLE_DEPTH = 16;

    // Field widths of a request and of a result
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned RSSI_W = 8;
    localparam int unsigned LQI_W  = 7;
    localparam int unsigned SLOT_W = 4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } nbtm_state_t;

    // Write request into the slot table
    typedef struct packed {
        logic              en;         // update rssi/lqi of the slot
        logic              new_entry;  // also store the address (append)
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [LQI_W-1:0]  lqi;
    } nbtm_wr_t;

endpackage

FILE: design/nbtm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbtm_table
// Slot storage: address, last RSSI and last LQI per slot. One write port and
// one registered read port on the address column for the scan.
// ----------------------------------------------------------------------------
module nbtm_table
    import nbtm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  logic              aclk,
    input  nbtm_wr_t          wr,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [ADDR_W-1:0] rd_addr
);

    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [RSSI_W-1:0] rssi_mem [TABLE_DEPTH];
    logic [LQI_W-1:0]  lqi_mem  [TABLE_DEPTH];
    logic [ADDR_W-1:0] rd_addr_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rssi_mem[wr_idx] <= wr.rssi;
            lqi_mem[wr_idx]  <= wr.lqi;
            if (wr.new_entry) begin
                addr_mem[wr_idx] <= wr.addr;
            end
        end
    end

    // Registered read of the address column
    always_ff @(posedge aclk) begin
        rd_addr_reg <= addr_mem[rd_idx];
    end

    assign rd_addr = rd_addr_reg;

endmodule

FILE: design/neighbor_table_max_rssi_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_max_rssi_unit
// Neighbor table keyed by sender address with a running peak RSSI.
//
// Usage: one request per received frame on the s_ channel (address, RSSI,
// LQI); exactly one result per request on the m_ channel (known, dropped,
// slot, peak RSSI). Both channels are valid/ready.
// A request is looked up by a linear scan of the used slots, one slot per
// cycle through a single address comparator fed by the registered read port
// of the slot memory. The scan stops on the first hit. Then the final state
// updates the slot and the peak (unless the frame is dropped) and loads the
// output register. s_ready is high only in the idle state, so a new request
// is not accepted until the previous one has been scanned and its result
// loaded into the output register.
// The output register lets a new request be accepted while the previous
// result waits; if m_ready stays low, the next request's update waits in its
// final state until the output register is free.
// Reset (aresetn low, synchronous) empties the table and clears the peak;
// slot contents are not cleared, unused slots are never compared.
// ----------------------------------------------------------------------------
module neighbor_table_max_rssi_unit
    import nbtm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ADDR_W-1:0] s_src_addr,
    input  logic [RSSI_W-1:0] s_rssi_value,
    input  logic [LQI_W-1:0]  s_lqi_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_was_known,
    output logic              m_was_dropped,
    output logic [SLOT_W-1:0] m_slot_index,
    output logic [RSSI_W-1:0] m_best_rssi
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    nbtm_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [RSSI_W-1:0] peak_reg, peak_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [RSSI_W-1:0] rssi_reg, rssi_next;
    logic [LQI_W-1:0]  lqi_reg, lqi_next;

    logic              m_valid_reg, m_valid_next;
    logic              known_reg, known_next;
    logic              dropped_reg, dropped_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [RSSI_W-1:0] best_reg, best_next;

    nbtm_wr_t          wr;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;

    logic              s_fire;
    logic              out_free;
    logic              is_last;
    logic              full;
    logic [IDX_W-1:0]  slot_sel;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    nbtm_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr      (wr),
        .wr_idx  (wr_idx),
        .rd_idx  (rd_idx),
        .rd_addr (rd_addr)
    );

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = ({1'b0, idx_reg} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(used_count_reg);
    assign full     = used_count_reg == FULL_CNT;
    assign slot_sel = found_reg ? idx_reg : used_count_reg[IDX_W-1:0];
    assign slot_ext = {{SLOT_W{1'b0}}, slot_sel};

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            peak_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            peak_reg       <= peak_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        addr_reg    <= addr_next;
        rssi_reg    <= rssi_next;
        lqi_reg     <= lqi_next;
        known_reg   <= known_next;
        dropped_reg <= dropped_next;
        slot_reg    <= slot_next;
        best_reg    <= best_next;
    end

    // Sequencer: accept, scan one slot per cycle, then update and report
    always_comb begin
        state_next      = state_reg;
        used_count_next = used_count_reg;
        peak_next       = peak_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        addr_next       = addr_reg;
        rssi_next       = rssi_reg;
        lqi_next        = lqi_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        known_next      = known_reg;
        dropped_next    = dropped_reg;
        slot_next       = slot_reg;
        best_next       = best_reg;
        s_ready         = 1'b0;
        rd_idx          = idx_reg + IDX_W'(1);
        wr              = '0;
        wr.addr         = addr_reg;
        wr.rssi         = rssi_reg;
        wr.lqi          = lqi_reg;
        wr_idx          = slot_sel;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_idx  = '0;
                if (s_fire) begin
                    addr_next  = s_src_addr;
                    rssi_next  = s_rssi_value;
                    lqi_next   = s_lqi_value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (used_count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_addr holds the slot at idx_reg; next slot is being read
                if (rd_addr == addr_reg) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (is_last) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    known_next   = found_reg;
                    if (!found_reg && full) begin
                        dropped_next = 1'b1;
                        slot_next    = '0;
                        best_next    = peak_reg;
                    end else begin
                        dropped_next = 1'b0;
                        slot_next    = slot_ext[SLOT_W-1:0];
                        wr.en        = 1'b1;
                        wr.new_entry = !found_reg;
                        if (!found_reg) begin
                            used_count_next = used_count_reg + CNT_W'(1);
                        end
                        if (rssi_reg > peak_reg) begin
                            peak_next = rssi_reg;
                        end
                        best_next = (rssi_reg > peak_reg) ? rssi_reg : peak_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_was_known   = known_reg;
    assign m_was_dropped = dropped_reg;
    assign m_slot_index  = slot_reg;
    assign m_best_rssi   = best_reg;

    // Checks
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= FULL_CNT)
        else $error("slot count beyond table depth");

    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_count_reg != $past(used_count_reg)) |->
        (used_count_reg == $past(used_count_reg) + CNT_W'(1)))
        else $error("slot count changed by other than one");

    a_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= $past(peak_reg))
        else $error("peak RSSI decreased");

    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(known_reg && dropped_reg))
        else $error("result both known and dropped");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((IDX_W + 1)'(idx_reg) < (IDX_W + 1)'(used_count_reg)))
        else $error("scan beyond used slots");

endmodule

FILE: sim/neighbor_table_max_rssi_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_max_rssi_unit_tb
// Self-checking bench for the neighbor table with running peak RSSI.
//
// Frames are sent on the s_ channel. Each accepted request goes through a
// local table model that predicts the known, dropped, slot and peak fields of
// its result. Results on the m_ channel are matched in order against those
// predictions. Directed frames fill the table and hit the corner cases, then
// random traffic runs under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module neighbor_table_max_rssi_unit_tb;
    import nbtm_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned TAIL_CYCLES = 2 * (TABLE_DEPTH + 2) + 4;

    // One expected result
    typedef struct packed {
        logic              known;
        logic              dropped;
        logic [SLOT_W-1:0] slot;
        logic [RSSI_W-1:0] best;
    } nb_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [ADDR_W-1:0] s_src_addr;
    logic [RSSI_W-1:0] s_rssi_value;
    logic [LQI_W-1:0]  s_lqi_value;
    logic              m_valid;
    logic              m_ready;
    logic              m_was_known;
    logic              m_was_dropped;
    logic [SLOT_W-1:0] m_slot_index;
    logic [RSSI_W-1:0] m_best_rssi;

    // Table model
    logic [ADDR_W-1:0] nb_addr [TABLE_DEPTH];
    logic [RSSI_W-1:0] nb_rssi [TABLE_DEPTH];
    logic [LQI_W-1:0]  nb_lqi  [TABLE_DEPTH];
    int unsigned       nb_used = 0;
    logic [RSSI_W-1:0] nb_peak = '0;

    nb_result_t  pending_results[$];
    int unsigned mismatch_count  = 0;
    int unsigned frames_sent     = 0;
    int unsigned cycle_count     = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;

    neighbor_table_max_rssi_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_src_addr   (s_src_addr),
        .s_rssi_value (s_rssi_value),
        .s_lqi_value  (s_lqi_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_was_known  (m_was_known),
        .m_was_dropped(m_was_dropped),
        .m_slot_index (m_slot_index),
        .m_best_rssi  (m_best_rssi)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Lookup, append or drop; returns the result the frame should produce
    function automatic nb_result_t predict_frame(input logic [ADDR_W-1:0] addr,
                                                 input logic [RSSI_W-1:0] rssi,
                                                 input logic [LQI_W-1:0] lqi);
        nb_result_t res;
        int slot;
        res = '0;
        slot = -1;
        for (int i = 0; i < nb_used; i++) begin
            if (slot < 0 && nb_addr[i] == addr) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            res.known = 1'b1;
        end else if (nb_used >= TABLE_DEPTH) begin
            res.dropped = 1'b1;
        end else begin
            slot = nb_used;
            nb_addr[slot] = addr;
            nb_used++;
        end
        if (!res.dropped) begin
            nb_rssi[slot] = rssi;
            nb_lqi[slot] = lqi;
            // peak moves only on a strictly higher value
            if (rssi > nb_peak) begin
                nb_peak = rssi;
            end
            res.slot = slot[SLOT_W-1:0];
        end
        res.best = nb_peak;
        return res;
    endfunction

    // Send one request; returns at the edge where it is accepted
    task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [RSSI_W-1:0] rssi,
                              input logic [LQI_W-1:0] lqi);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_src_addr   <= addr;
        s_rssi_value <= rssi;
        s_lqi_value  <= lqi;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_frame(addr, rssi, lqi));
        frames_sent++;
    endtask

    // Hold off the sender until every result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Empty table, re-hit, equal and lower RSSI, address extremes
    task automatic test_first_frames();
        sender_idle_pct = 30;
        recv_stall_pct  = 30;
        send_frame(16'h0000, 8'd0, 7'd0);
        send_frame(16'h0000, 8'd20, 7'd127);
        send_frame(16'hFFFF, 8'd20, 7'd1);
        send_frame(16'hFFFF, 8'd5, 7'd64);
    endtask

    // Append until every slot is used
    task automatic test_table_fill();
        for (int k = 0; k < TABLE_DEPTH - 2; k++) begin
            send_frame(ADDR_W'(16'h1000 + k * 16'h0111), 8'($urandom_range(30)),
                       7'($urandom_range(127)));
        end
    endtask

    // Drops leave the peak alone; hits on the first and last slot still work
    task automatic test_full_table();
        send_frame(16'h8000, 8'd255, 7'd127);
        send_frame(16'h7FFF, 8'd0, 7'd0);
        send_frame(nb_addr[TABLE_DEPTH-1], 8'd35, 7'd127);
        send_frame(16'h0000, 8'd35, 7'd0);
        wait_for_results();
    endtask

    // Mostly known senders, some strangers; the RSSI range widens over the run
    task automatic run_random_frames(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        logic [ADDR_W-1:0] addr;
        int unsigned cap;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count) begin
            if ($urandom_range(3) != 0) begin
                addr = nb_addr[$urandom_range(nb_used - 1)];
            end else begin
                addr = ADDR_W'($urandom);
            end
            cap = 40 + frames_sent / 8;
            if (cap > 255) begin
                cap = 255;
            end
            send_frame(addr, RSSI_W'($urandom_range(cap)), LQI_W'($urandom_range(127)));
            if ($urandom_range(99) == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_random_frames(500, 0, 0);
        run_random_frames(500, 77, 0);
        run_random_frames(500, 0, 77);
        run_random_frames(500, 30, 30);
    endtask

    // Receiver stalls and result check
    always @(posedge aclk) begin
        nb_result_t got;
        nb_result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            got = {m_was_known, m_was_dropped, m_slot_index, m_best_rssi};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result known=%0d dropped=%0d slot=%0d best=%0d",
                             got.known, got.dropped, got.slot, got.best);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: result mismatch at %0t", $realtime);
                        $display("  expected known=%0d dropped=%0d slot=%0d best=%0d",
                                 want.known, want.dropped, want.slot, want.best);
                        $display("  actual   known=%0d dropped=%0d slot=%0d best=%0d",
                                 got.known, got.dropped, got.slot, got.best);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("neighbor_table_max_rssi_unit_tb failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_src_addr   <= '0;
        s_rssi_value <= '0;
        s_lqi_value  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_frames();
        test_table_fill();
        test_full_table();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("ERROR: %0d results never arrived", pending_results.size());
        end
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("neighbor_table_max_rssi_unit_tb passed");
        end else begin
            $display("neighbor_table_max_rssi_unit_tb failed");
        end
        $finish;
    end

endmodule
